// File: hw/rtl/ec_pkg.sv
package ec_pkg;

    localparam int unsigned EpochYear    = 1970;
    localparam int unsigned SecPerHour   = 3600;
    localparam int unsigned SecPerMin    = 60;
    localparam int unsigned MinPerHour   = 60;
    localparam int unsigned DaysPerWeek  = 7;
    localparam int unsigned EpochWdayOfs = 4;    // 1970-01-01 was a Thursday

    // quotients by constants: floor(x * ceil(2^s / d) / 2^s), exact over each operand range
    localparam int unsigned SecPerDayHi  = 675;        // 86400 >> 7
    localparam int unsigned DayRecip     = 50903317;   // 2^35 / 675, x < 2^25
    localparam int unsigned WdayRecip    = 74899;      // 2^19 / 7,   x < 2^16
    localparam int unsigned ModRecip     = 34953;      // 2^19 / 15,  x < 2^15
    localparam int unsigned HourRecip    = 9321;       // 2^21 / 225, x < 2^13

    typedef enum logic [1:0] {
        DIV_SRC_DAYS,
        DIV_SRC_SOD,
        DIV_SRC_MOD,
        DIV_SRC_SPLIT
    } div_src_t;

    // controller -> datapath
    typedef struct packed {
        logic     take_in;
        logic     div_load;
        div_src_t div_src;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } ec_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic year_done;
        logic month_done;
    } ec_sts_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/ec_ctrl.sv
module ec_ctrl
    import ec_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  ec_sts_t sts,
    output ec_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_SOD,
        S_MOD,
        S_SPLIT,
        S_YEAR,
        S_MONTH,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Steps through each stage of the reciprocal split, then the year and month searches.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.div_src  = DIV_SRC_DAYS;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = S_DAYS;
                end
            end
            S_DAYS: begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_DAYS;
                state_next   = S_SOD;
            end
            S_SOD: begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_SOD;
                state_next   = S_MOD;
            end
            S_MOD: begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_MOD;
                state_next   = S_SPLIT;
            end
            S_SPLIT: begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_SPLIT;
                state_next   = S_YEAR;
            end
            S_YEAR: begin
                if (sts.year_done) begin
                    state_next = S_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (sts.month_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/ec_dp.sv
module ec_dp
    import ec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic [31:0] s_epoch_seconds,
    input  ec_cmd_t     cmd,
    output ec_sts_t     sts,
    output logic [5:0]  m_second_of_minute,
    output logic [5:0]  m_minute_of_hour,
    output logic [4:0]  m_hour_of_day,
    output logic [3:0]  m_hour_twelve,
    output logic        m_is_pm,
    output logic [2:0]  m_weekday,
    output logic [4:0]  m_day_of_month,
    output logic [3:0]  m_month_of_year,
    output logic [11:0] m_calendar_year
);

    logic [4:0]  zone_reg;

    logic [31:0] num_reg;
    logic [15:0] days_reg;
    logic [16:0] sod_reg;
    logic [10:0] mod_reg;
    logic [12:0] wk_q_reg;
    logic [2:0]  wday_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hr_reg;
    logic [11:0] year_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  month_reg;

    logic [5:0]  out_sec_reg, out_min_reg;
    logic [4:0]  out_hr_reg, out_dom_reg;
    logic [3:0]  out_h12_reg, out_mon_reg;
    logic        out_pm_reg;
    logic [2:0]  out_wday_reg;
    logic [11:0] out_year_reg;

    logic [31:0] t_sum;
    logic [50:0] day_prod;
    logic [24:0] day_back;
    logic [9:0]  sod_hi;
    logic [15:0] wk_num;
    logic [31:0] wk_prod;
    logic [2:0]  wk_rem;
    logic [29:0] mod_prod;
    logic [25:0] hr_prod;
    logic [5:0]  sec_val;
    logic [5:0]  min_val;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [3:0]  h12;

    assign t_sum = s_epoch_seconds + 32'(zone_reg) * 32'(SecPerHour);

    // t / 86400 = (t >> 7) / 675; remainder rebuilt from the high part and the low 7 bits
    assign day_prod = 51'(num_reg[31:7]) * 51'(DayRecip);
    assign day_back = 25'(days_reg) * 25'(SecPerDayHi);
    assign sod_hi   = 10'(num_reg[31:7] - day_back);

    assign wk_num  = days_reg + 16'(EpochWdayOfs);
    assign wk_prod = 32'(wk_num) * 32'(WdayRecip);
    assign wk_rem  = 3'(wk_num - 16'(wk_q_reg) * 16'(DaysPerWeek));

    // minutes of day = (sod >> 2) / 15, hour = (sod >> 4) / 225
    assign mod_prod = 30'(sod_reg[16:2]) * 30'(ModRecip);
    assign hr_prod  = 26'(sod_reg[16:4]) * 26'(HourRecip);
    assign sec_val  = 6'(sod_reg - 17'(mod_reg) * 17'(SecPerMin));
    assign min_val  = 6'(mod_reg - 11'(hr_reg) * 11'(MinPerHour));

    // leap: divisible by 4, and not by 100 unless by 400
    assign leap = (year_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(month_reg, leap);

    assign sts.year_done  = (days_reg < {7'd0, ylen});
    assign sts.month_done = (days_reg < {11'd0, mlen}) || (month_reg == 4'd11);

    always_comb begin
        if (hr_reg == 5'd0) begin
            h12 = 4'd12;
        end else if (hr_reg > 5'd12) begin
            h12 = 4'(hr_reg - 5'd12);
        end else begin
            h12 = hr_reg[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= '0;
        end else if (cfg_wr_en) begin
            zone_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            num_reg   <= t_sum;
            year_reg  <= 12'(EpochYear);
            c100_reg  <= 7'(EpochYear % 100);
            c400_reg  <= 9'(EpochYear % 400);
            month_reg <= '0;
        end
        if (cmd.div_load) begin
            case (cmd.div_src)
                DIV_SRC_DAYS: begin
                    days_reg <= day_prod[50:35];
                end
                DIV_SRC_SOD: begin
                    sod_reg  <= {sod_hi, num_reg[6:0]};
                    wk_q_reg <= wk_prod[31:19];
                end
                DIV_SRC_MOD: begin
                    mod_reg  <= mod_prod[29:19];
                    hr_reg   <= hr_prod[25:21];
                    wday_reg <= wk_rem + 3'd1;
                end
                DIV_SRC_SPLIT: begin
                    sec_reg <= sec_val;
                    min_reg <= min_val;
                end
                default: begin
                    days_reg <= days_reg;
                end
            endcase
        end
        if (cmd.year_step) begin
            days_reg <= days_reg - {7'd0, ylen};
            year_reg <= year_reg + 12'd1;
            c100_reg <= (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
        end
        if (cmd.month_step) begin
            days_reg  <= days_reg - {11'd0, mlen};
            month_reg <= month_reg + 4'd1;
        end
        if (cmd.out_load) begin
            out_sec_reg  <= sec_reg;
            out_min_reg  <= min_reg;
            out_hr_reg   <= hr_reg;
            out_h12_reg  <= h12;
            out_pm_reg   <= (hr_reg >= 5'd12);
            out_wday_reg <= wday_reg;
            out_dom_reg  <= 5'(days_reg + 16'd1);
            out_mon_reg  <= month_reg + 4'd1;
            out_year_reg <= year_reg;
        end
    end

    assign m_second_of_minute = out_sec_reg;
    assign m_minute_of_hour   = out_min_reg;
    assign m_hour_of_day      = out_hr_reg;
    assign m_hour_twelve      = out_h12_reg;
    assign m_is_pm            = out_pm_reg;
    assign m_weekday          = out_wday_reg;
    assign m_day_of_month     = out_dom_reg;
    assign m_month_of_year    = out_mon_reg;
    assign m_calendar_year    = out_year_reg;

endmodule

// File: hw/rtl/epoch_to_calendar.sv
// Converts 32-bit Unix epoch seconds, shifted by a whole-hour zone offset from
// cfg_wr_data, into local Gregorian date, time and weekday (Sunday is 1), years
// 1970 to 2106. One item is converted at a time: the split states turn the sum into
// day count, second, minute, hour and weekday by multiplying with fixed
// reciprocals; then the year search steps one year at a time from 1970, and the
// month search one month at a time. The result is then loaded into the output
// register, and only after that is a new item taken. A result held by m_ready
// keeps the conversion waiting in its last state, before the load.
module epoch_to_calendar
    import ec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_second_of_minute,
    output logic [5:0]  m_minute_of_hour,
    output logic [4:0]  m_hour_of_day,
    output logic [3:0]  m_hour_twelve,
    output logic        m_is_pm,
    output logic [2:0]  m_weekday,
    output logic [4:0]  m_day_of_month,
    output logic [3:0]  m_month_of_year,
    output logic [11:0] m_calendar_year
);

    ec_cmd_t cmd;
    ec_sts_t sts;

    ec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ec_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_epoch_seconds    (s_epoch_seconds),
        .cmd                (cmd),
        .sts                (sts),
        .m_second_of_minute (m_second_of_minute),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_hour_of_day      (m_hour_of_day),
        .m_hour_twelve      (m_hour_twelve),
        .m_is_pm            (m_is_pm),
        .m_weekday          (m_weekday),
        .m_day_of_month     (m_day_of_month),
        .m_month_of_year    (m_month_of_year),
        .m_calendar_year    (m_calendar_year)
    );

    // one item in flight: intake closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while conversion busy");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_of_year >= 4'd1) && (m_month_of_year <= 4'd12) &&
                    (m_day_of_month != 5'd0) && (m_weekday != 3'd0))
        else $error("date field out of range");

    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_calendar_year >= 12'd1970) && (m_calendar_year <= 12'd2106) &&
                    (m_is_pm == (m_hour_of_day >= 5'd12)))
        else $error("year or hour field inconsistent");

endmodule
